[hdl/sset_pkg.sv]
// ----------------------------------------------------------------------------
// sset_pkg: shared types and constants for the sorted set store engine
// Sizes, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package sset_pkg;
  localparam int NUM_SETS    = 16;
  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int SET_W       = $clog2(NUM_SETS);
  localparam int POS_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ADDR_W      = SET_W + POS_W;
  localparam int DEPTH       = NUM_SETS * CAPACITY;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0, OP_INSERT = 3'd1, OP_REMOVE = 3'd2, OP_MEMBER = 3'd3,
    OP_UNION  = 3'd4, OP_INTER  = 3'd5, OP_DIFF   = 3'd6, OP_READ   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0, KIND_ELEM = 2'd1, KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOSET = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for an item
    S_SCAN,   // search issue
    S_SCANW,  // search compare
    S_SHIFT,  // shift read issue
    S_SHIFTW, // shift write
    S_PUT,    // write inserted value
    S_MRD,    // merge: read a/b heads
    S_MCMP,   // merge: compare, push to buffer
    S_MCOPY,  // merge: copy buffer to destination
    S_RDO,    // read out issue
    S_RDOW,   // read out present
    S_REPLY   // status reply present
  } state_t;
endpackage
`default_nettype wire

[hdl/sset_ram.sv]
// ----------------------------------------------------------------------------
// sset_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[hdl/sorted_set_store_engine_core.sv]
// ----------------------------------------------------------------------------
// sorted_set_store_engine_core: bank of sorted duplicate-free sets
// Sequencer around one element RAM, a merge buffer RAM and one comparator.
// ----------------------------------------------------------------------------
// Usage:
//  - Input beat (in_valid/in_stall): operation, set_id, source_a, source_b,
//    value. in_stall is high whenever an operation is in progress; one item
//    is worked on at a time, from accept until its last output beat leaves.
//  - Output beats (out_valid/out_stall): one status beat for operations
//    0..6, a run of element beats (or one empty beat) for read out, with
//    out_last on the final beat. The sequencer holds an output beat while out_stall is high.
//  - Sequence: element RAM is single ported with registered read. Insert,
//    remove and member search the set from its start; insert and remove
//    then shift the tail. A merge compares the source heads and pushes
//    into the merge buffer, then copies the buffer back to the destination;
//    read out visits each element in order.
//  - Reset: counts and exists bits clear at once (synchronous, active low);
//    element memory is not cleared, only entries below a count are read.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_set_store_engine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic [3:0]  in_set_id,
  input  wire logic [3:0]  in_source_a,
  input  wire logic [3:0]  in_source_b,
  input  wire logic signed [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic signed [31:0] out_element,
  output logic             out_found,
  output logic [1:0]       out_status,
  output logic             out_last
);
  localparam int VW = sset_pkg::VALUE_WIDTH;
  localparam int PW = sset_pkg::POS_W;
  localparam int CW = sset_pkg::CNT_W;
  localparam int SW = sset_pkg::SET_W;
  localparam int AW = sset_pkg::ADDR_W;

  sset_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r [sset_pkg::NUM_SETS];
  logic [sset_pkg::NUM_SETS-1:0] ex_r;

  logic [2:0]    op_r;
  logic [SW-1:0] sid_r, sa_r, sb_r;
  logic [VW-1:0] val_r;
  logic [CW-1:0] i_r, j_r, n_r;     // positions / counters
  logic [CW-1:0] na_r, nb_r;
  logic          phase_r;           // merge: 0 read a, 1 read b
  logic [VW-1:0] ea_r;
  logic          trunc_r, found_r;
  logic [1:0]    stat_r;
  logic [VW-1:0] hold_r;            // shift carry value

  // RAM ports
  logic          we;
  logic [AW-1:0] addr;
  logic [VW-1:0] wdata, rdata;
  logic          bwe;
  logic [PW-1:0] baddr;
  logic [VW-1:0] bwdata, brdata;

  sset_ram #(.WIDTH(VW), .DEPTH(sset_pkg::DEPTH)) u_elem (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));
  sset_ram #(.WIDTH(VW), .DEPTH(sset_pkg::CAPACITY)) u_buf (
    .clk(clk), .we(bwe), .addr(baddr), .wdata(bwdata), .rdata(brdata));

  // signed compare, the single shared comparator
  logic [VW-1:0] cmp_x, cmp_y;
  logic          lt, eq;
  assign lt = $signed(cmp_x) < $signed(cmp_y);
  assign eq = cmp_x == cmp_y;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = state_r != sset_pkg::S_IDLE;

  logic [SW:0] in_sid_w;
  assign in_sid_w = {1'b0, in_set_id};
  logic in_sid_ok, in_tgt_ok, in_src_ok, in_merge;
  assign in_sid_ok = in_sid_w < (SW+1)'(sset_pkg::NUM_SETS);
  assign in_tgt_ok = in_sid_ok && ex_r[in_set_id];
  assign in_src_ok = ex_r[in_source_a] && ex_r[in_source_b];
  assign in_merge  = in_operation inside {sset_pkg::OP_UNION, sset_pkg::OP_INTER,
                                          sset_pkg::OP_DIFF};

  // status known at accept time
  logic [1:0] in_stat;
  always_comb begin
    in_stat = sset_pkg::ST_OK;
    case (sset_pkg::op_t'(in_operation))
      sset_pkg::OP_CREATE:
        if (!in_sid_ok) in_stat = sset_pkg::ST_NOSET;
      sset_pkg::OP_INSERT, sset_pkg::OP_REMOVE, sset_pkg::OP_MEMBER,
      sset_pkg::OP_READ:
        if (!in_tgt_ok) in_stat = sset_pkg::ST_NOSET;
      default:
        if (!(in_sid_ok && in_src_ok)) in_stat = sset_pkg::ST_NOSET;
    endcase
  end

  logic [CW-1:0] cap_c;
  assign cap_c = CW'(sset_pkg::CAPACITY);

  // merge decision
  logic a_has, b_has, take_a, take_b, take, from_a;
  assign a_has = i_r < na_r;
  assign b_has = j_r < nb_r;

  always_comb begin
    cmp_x = ea_r;
    cmp_y = rdata;
    if (state_r == sset_pkg::S_SCANW) begin
      cmp_x = rdata;
      cmp_y = val_r;
    end
  end

  always_comb begin
    take_a = 1'b0; take_b = 1'b0; take = 1'b0; from_a = 1'b1;
    if (a_has && b_has) begin
      if (lt) begin
        take_a = 1'b1; take = op_r != sset_pkg::OP_INTER;
      end else if (!eq) begin
        take_b = 1'b1; from_a = 1'b0; take = op_r == sset_pkg::OP_UNION;
      end else begin
        take_a = 1'b1; take_b = 1'b1; take = op_r != sset_pkg::OP_DIFF;
      end
    end else if (a_has) begin
      take_a = 1'b1; take = op_r != sset_pkg::OP_INTER;
    end else begin
      take_b = 1'b1; from_a = 1'b0; take = op_r == sset_pkg::OP_UNION;
    end
  end

  // --- shift phase: entered with i_r = p, hit_r known ---
  // insert: walk k from p..top, writing carry and picking up old e[k]
  // remove: walk k from p..n-2, e[k] = e[k+1]
  logic hit_r;
  logic [CW-1:0] k_r;
  sset_pkg::state_t shift_next;
  logic [CW-1:0] top_c;
  assign top_c = (n_r < cap_c) ? n_r : cap_c - CW'(1);

  always_comb begin
    shift_next = sset_pkg::S_SHIFTW;
    if (state_r == sset_pkg::S_SHIFT) begin
      case (op_r)
        sset_pkg::OP_MEMBER: shift_next = sset_pkg::S_REPLY;
        sset_pkg::OP_INSERT:
          if (hit_r || (n_r >= cap_c && i_r >= cap_c)) shift_next = sset_pkg::S_REPLY;
          else if (k_r >= top_c) shift_next = sset_pkg::S_PUT;
          else shift_next = sset_pkg::S_SHIFTW;
        sset_pkg::OP_REMOVE:
          if (!hit_r || k_r + CW'(1) >= n_r) shift_next = sset_pkg::S_REPLY;
          else shift_next = sset_pkg::S_SHIFTW;
        default: shift_next = sset_pkg::S_REPLY;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sset_pkg::S_IDLE: begin
        if (in_acc) begin
          case (sset_pkg::op_t'(in_operation))
            sset_pkg::OP_CREATE: state_nxt = sset_pkg::S_REPLY;
            sset_pkg::OP_INSERT, sset_pkg::OP_REMOVE, sset_pkg::OP_MEMBER:
              state_nxt = in_tgt_ok ? sset_pkg::S_SCAN : sset_pkg::S_REPLY;
            sset_pkg::OP_READ:
              state_nxt = in_tgt_ok ? sset_pkg::S_RDO : sset_pkg::S_REPLY;
            default:
              state_nxt = (in_sid_ok && in_src_ok) ? sset_pkg::S_MRD
                                                   : sset_pkg::S_REPLY;
          endcase
        end
      end
      sset_pkg::S_SCAN:
        state_nxt = (i_r < n_r) ? sset_pkg::S_SCANW : sset_pkg::S_SHIFT;
      sset_pkg::S_SCANW:
        state_nxt = lt ? sset_pkg::S_SCAN : sset_pkg::S_SHIFT;
      sset_pkg::S_SHIFT: begin
        // decide action at position i_r (scan stop point p)
        state_nxt = sset_pkg::S_SHIFTW;
      end
      sset_pkg::S_SHIFTW: state_nxt = sset_pkg::S_SHIFT;
      sset_pkg::S_PUT:    state_nxt = sset_pkg::S_REPLY;
      sset_pkg::S_MRD:
        state_nxt = (!a_has && !b_has) ? sset_pkg::S_MCOPY : sset_pkg::S_MCMP;
      sset_pkg::S_MCMP:   state_nxt = phase_r ? sset_pkg::S_MRD : sset_pkg::S_MCMP;
      sset_pkg::S_MCOPY:  state_nxt = (j_r >= n_r && !phase_r) ? sset_pkg::S_REPLY
                                                               : sset_pkg::S_MCOPY;
      sset_pkg::S_RDO:    state_nxt = sset_pkg::S_RDOW;
      sset_pkg::S_RDOW:
        if (out_acc) state_nxt = out_last ? sset_pkg::S_IDLE : sset_pkg::S_RDO;
      sset_pkg::S_REPLY:
        if (out_acc) state_nxt = sset_pkg::S_IDLE;
      default: state_nxt = sset_pkg::S_IDLE;
    endcase
    // the shift/put path overrides, computed in the shift-phase block above
    if (state_r == sset_pkg::S_SHIFT) state_nxt = shift_next;
    if (state_r == sset_pkg::S_SCANW && !lt) state_nxt = sset_pkg::S_SHIFT;
  end

  // memory address/write control
  logic [PW-1:0] pos_sel;
  always_comb begin
    we = 1'b0; wdata = hold_r; bwe = 1'b0; bwdata = ea_r;
    pos_sel = i_r[PW-1:0]; baddr = j_r[PW-1:0];
    addr = {sid_r, pos_sel};
    case (state_r)
      sset_pkg::S_SCAN:  pos_sel = i_r[PW-1:0];
      sset_pkg::S_SHIFT: pos_sel = (op_r == sset_pkg::OP_REMOVE) ?
                                   PW'(k_r + CW'(1)) : k_r[PW-1:0];
      sset_pkg::S_SHIFTW: begin
        pos_sel = k_r[PW-1:0]; we = 1'b1;
        wdata = (op_r == sset_pkg::OP_REMOVE) ? rdata : hold_r;
      end
      sset_pkg::S_PUT: begin
        pos_sel = k_r[PW-1:0]; we = 1'b1; wdata = hold_r;
      end
      sset_pkg::S_MRD: begin
        pos_sel = i_r[PW-1:0];
        addr = {sa_r, pos_sel};
      end
      sset_pkg::S_MCMP: begin
        pos_sel = j_r[PW-1:0];
        addr = {sb_r, pos_sel};
        if (phase_r && take && n_r < cap_c) begin
          bwe = 1'b1; baddr = n_r[PW-1:0]; bwdata = from_a ? ea_r : rdata;
        end
      end
      sset_pkg::S_MCOPY: begin
        baddr = j_r[PW-1:0];
        pos_sel = i_r[PW-1:0];
        we = phase_r; wdata = brdata;
      end
      sset_pkg::S_RDO: pos_sel = i_r[PW-1:0];
      default: ;
    endcase
    if (state_r != sset_pkg::S_MRD && state_r != sset_pkg::S_MCMP)
      addr = {sid_r, pos_sel};
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sset_pkg::S_IDLE;
      ex_r    <= '0;
      for (int s = 0; s < sset_pkg::NUM_SETS; s++) cnt_r[s] <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        sset_pkg::S_IDLE: if (in_acc) begin
          op_r <= in_operation; sid_r <= in_set_id[SW-1:0];
          sa_r <= in_source_a[SW-1:0]; sb_r <= in_source_b[SW-1:0];
          val_r <= VW'(in_value);
          hold_r <= VW'(in_value);
          i_r <= '0; j_r <= '0; k_r <= '0; phase_r <= 1'b0;
          hit_r <= 1'b0; found_r <= 1'b0; trunc_r <= 1'b0;
          // merges count their result buffer up from zero
          n_r <= in_merge ? '0 : cnt_r[in_set_id[SW-1:0]];
          na_r <= cnt_r[in_source_a[SW-1:0]];
          nb_r <= cnt_r[in_source_b[SW-1:0]];
          stat_r <= in_stat;
          if (in_operation == sset_pkg::OP_CREATE && in_sid_ok) begin
            ex_r[in_set_id[SW-1:0]] <= 1'b1;
            cnt_r[in_set_id[SW-1:0]] <= '0;
          end
        end
        sset_pkg::S_SCANW: begin
          if (lt) i_r <= i_r + CW'(1);
          else begin
            hit_r <= eq;
            found_r <= eq;
          end
          k_r <= lt ? i_r + CW'(1) : i_r;
        end
        sset_pkg::S_SCAN: if (!(i_r < n_r)) k_r <= i_r;
        sset_pkg::S_SHIFT:
          if (shift_next == sset_pkg::S_REPLY) begin
            if (op_r == sset_pkg::OP_INSERT && !hit_r)
              stat_r <= sset_pkg::ST_FULL;
            if (op_r == sset_pkg::OP_REMOVE && hit_r)
              cnt_r[sid_r] <= n_r - CW'(1);
          end
        sset_pkg::S_SHIFTW: begin
          if (op_r == sset_pkg::OP_INSERT) hold_r <= rdata;
          k_r <= k_r + CW'(1);
        end
        sset_pkg::S_PUT:
          if (n_r < cap_c) cnt_r[sid_r] <= n_r + CW'(1);
          else stat_r <= sset_pkg::ST_FULL;
        sset_pkg::S_MCMP:
          if (!phase_r) begin
            phase_r <= 1'b1;
            ea_r <= rdata;
          end else begin
            phase_r <= 1'b0;
            if (take_a) i_r <= i_r + CW'(1);
            if (take_b) j_r <= j_r + CW'(1);
            if (take) begin
              if (n_r < cap_c) n_r <= n_r + CW'(1);
              else trunc_r <= 1'b1;
            end
            if (!(a_has && b_has)) ea_r <= a_has ? ea_r : rdata;
          end
        sset_pkg::S_MRD: if (!a_has && !b_has) begin
          i_r <= '0; j_r <= '0; phase_r <= 1'b0;
        end
        sset_pkg::S_MCOPY:
          if (!phase_r) begin
            if (j_r < n_r) begin
              phase_r <= 1'b1;
              i_r <= j_r;
              j_r <= j_r + CW'(1);
            end else begin
              cnt_r[sid_r] <= n_r; ex_r[sid_r] <= 1'b1;
              stat_r <= trunc_r ? sset_pkg::ST_FULL : sset_pkg::ST_OK;
            end
          end else phase_r <= 1'b0;
        sset_pkg::S_RDOW: if (out_acc) i_r <= i_r + CW'(1);
        default: ;
      endcase
    end
  end

  // merge with a head missing: when one source is exhausted the compare
  // only uses the live side, so the first read (source a) is still fine.
  logic [CW-1:0] i_plus;
  assign i_plus = i_r + CW'(1);

  // outputs
  always_comb begin
    out_valid = 1'b0; out_kind = sset_pkg::KIND_STATUS; out_element = '0;
    out_found = 1'b0; out_status = stat_r; out_last = 1'b1;
    case (state_r)
      sset_pkg::S_REPLY: begin
        out_valid = 1'b1;
        out_found = (op_r == sset_pkg::OP_MEMBER) && found_r &&
                    stat_r == sset_pkg::ST_OK;
      end
      sset_pkg::S_RDOW: begin
        out_valid = 1'b1;
        out_status = sset_pkg::ST_OK;
        if (n_r == '0) out_kind = sset_pkg::KIND_EMPTY;
        else begin
          out_kind = sset_pkg::KIND_ELEM;
          out_element = 32'(rdata);
          out_last = i_plus >= n_r;
        end
      end
      default: ;
    endcase
  end

  property p_idle_reply;
    @(posedge clk) disable iff (!rst_n)
      (state_r == sset_pkg::S_REPLY && out_stall) |=> state_r == sset_pkg::S_REPLY;
  endproperty
  a_idle_reply: assert property (p_idle_reply) else $error("reply dropped");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r != sset_pkg::S_IDLE) |-> in_stall)
    else $error("accepted while busy");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == sset_pkg::S_MCMP) |-> n_r <= cap_c)
    else $error("merge count beyond capacity");
endmodule
`default_nettype wire

[bench/sorted_set_store_engine_core_tb.sv]
// ----------------------------------------------------------------------------
// sorted_set_store_engine_core_tb: self-checking bench for the set engine
// Drives operations on a small pool of sets, predicts every reply beat with a
// behavioral model of the set bank, and compares each output beat in order.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_set_store_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sset_pkg::kind_t   kind;
    logic [31:0]       element;
    logic              found;
    sset_pkg::status_t status;
    logic              last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_operation = '0;
  logic [3:0] in_set_id = '0;
  logic [3:0] in_source_a = '0;
  logic [3:0] in_source_b = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic signed [31:0] out_element;
  logic out_found;
  logic [1:0] out_status;
  logic out_last;

  sorted_set_store_engine_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the set bank
  logic signed [31:0] bank_elems [sset_pkg::NUM_SETS][sset_pkg::CAPACITY];
  int unsigned        bank_count [sset_pkg::NUM_SETS];
  bit                 bank_live  [sset_pkg::NUM_SETS];
  reply_t             pending_replies [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;
  int  mismatches = 0;
  longint cycles = 0;

  function automatic void push_reply(sset_pkg::kind_t k, logic [31:0] e, logic f,
                                     sset_pkg::status_t s, logic l);
    reply_t r;
    r.kind = k; r.element = e; r.found = f; r.status = s; r.last = l;
    pending_replies.push_back(r);
  endfunction

  // Position of the first element not below v (signed order)
  function automatic int unsigned find_slot(int unsigned sid, logic signed [31:0] v);
    int unsigned p;
    p = 0;
    while (p < bank_count[sid] && bank_elems[sid][p] < v) p++;
    return p;
  endfunction

  function automatic bit is_live(int unsigned sid);
    return sid < sset_pkg::NUM_SETS && bank_live[sid];
  endfunction

  // Apply one operation to the shadow bank and queue the beats it produces
  function automatic void predict_op(sset_pkg::op_t op, int unsigned sid,
                                     int unsigned sa, int unsigned sb,
                                     logic signed [31:0] v);
    sset_pkg::status_t st;
    logic fnd;
    int unsigned p, n, i, j, top, cnt;
    logic signed [31:0] merged [sset_pkg::CAPACITY];
    logic signed [31:0] x;
    bit take, trunc;
    st = sset_pkg::ST_OK; fnd = 1'b0;
    case (op)
      sset_pkg::OP_CREATE: begin
        bank_live[sid] = 1'b1;
        bank_count[sid] = 0;
      end
      sset_pkg::OP_INSERT: begin
        if (!is_live(sid)) st = sset_pkg::ST_NOSET;
        else begin
          n = bank_count[sid];
          p = find_slot(sid, v);
          if (!(p < n && bank_elems[sid][p] == v)) begin
            if (n >= sset_pkg::CAPACITY && p >= sset_pkg::CAPACITY)
              st = sset_pkg::ST_FULL;
            else begin
              top = (n < sset_pkg::CAPACITY) ? n : sset_pkg::CAPACITY - 1;
              for (i = top; i > p; i--) bank_elems[sid][i] = bank_elems[sid][i-1];
              bank_elems[sid][p] = v;
              if (n < sset_pkg::CAPACITY) bank_count[sid] = n + 1;
              else st = sset_pkg::ST_FULL;
            end
          end
        end
      end
      sset_pkg::OP_REMOVE: begin
        if (!is_live(sid)) st = sset_pkg::ST_NOSET;
        else begin
          n = bank_count[sid];
          p = find_slot(sid, v);
          if (p < n && bank_elems[sid][p] == v) begin
            for (i = p; i + 1 < n; i++) bank_elems[sid][i] = bank_elems[sid][i+1];
            bank_count[sid] = n - 1;
          end
        end
      end
      sset_pkg::OP_MEMBER: begin
        if (!is_live(sid)) st = sset_pkg::ST_NOSET;
        else begin
          p = find_slot(sid, v);
          fnd = (p < bank_count[sid] && bank_elems[sid][p] == v);
        end
      end
      sset_pkg::OP_UNION, sset_pkg::OP_INTER, sset_pkg::OP_DIFF: begin
        if (!(is_live(sa) && is_live(sb))) st = sset_pkg::ST_NOSET;
        else begin
          i = 0; j = 0; cnt = 0; trunc = 1'b0;
          while (i < bank_count[sa] || j < bank_count[sb]) begin
            if (i < bank_count[sa] && j < bank_count[sb]) begin
              if (bank_elems[sa][i] < bank_elems[sb][j]) begin
                x = bank_elems[sa][i]; i++; take = (op != sset_pkg::OP_INTER);
              end else if (bank_elems[sa][i] > bank_elems[sb][j]) begin
                x = bank_elems[sb][j]; j++; take = (op == sset_pkg::OP_UNION);
              end else begin
                x = bank_elems[sa][i]; i++; j++; take = (op != sset_pkg::OP_DIFF);
              end
            end else if (i < bank_count[sa]) begin
              x = bank_elems[sa][i]; i++; take = (op != sset_pkg::OP_INTER);
            end else begin
              x = bank_elems[sb][j]; j++; take = (op == sset_pkg::OP_UNION);
            end
            if (take) begin
              if (cnt < sset_pkg::CAPACITY) begin
                merged[cnt] = x; cnt++;
              end else trunc = 1'b1;
            end
          end
          for (i = 0; i < cnt; i++) bank_elems[sid][i] = merged[i];
          bank_count[sid] = cnt;
          bank_live[sid] = 1'b1;
          st = trunc ? sset_pkg::ST_FULL : sset_pkg::ST_OK;
        end
      end
      default: begin
        if (!is_live(sid)) st = sset_pkg::ST_NOSET;
        else if (bank_count[sid] == 0) begin
          push_reply(sset_pkg::KIND_EMPTY, '0, 1'b0, sset_pkg::ST_OK, 1'b1);
          return;
        end else begin
          for (i = 0; i < bank_count[sid]; i++)
            push_reply(sset_pkg::KIND_ELEM, bank_elems[sid][i], 1'b0, sset_pkg::ST_OK,
                       i + 1 == bank_count[sid]);
          return;
        end
      end
    endcase
    push_reply(sset_pkg::KIND_STATUS, '0, fnd, st, 1'b1);
  endfunction

  // Present one beat, hold it until accepted, then predict it
  task automatic send_op(sset_pkg::op_t op, int unsigned sid, int unsigned sa = 0,
                         int unsigned sb = 0, logic signed [31:0] v = 0);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_operation = op; in_set_id = sid; in_source_a = sa; in_source_b = sb;
    in_value = v; in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_op(op, sid, sa, sb, v);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Receiver backpressure
  always @(negedge clk)
    out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);

  // Output checker: compare each accepted beat with the oldest prediction
  always @(posedge clk) begin
    reply_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.kind = sset_pkg::kind_t'(out_kind); got.element = out_element;
      got.found = out_found;
      got.status = sset_pkg::status_t'(out_status); got.last = out_last;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2_000_000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom;
      default: return $signed($urandom_range(40)) - 20;
    endcase
  endfunction

  task automatic test_directed();
    send_op(sset_pkg::OP_READ, 3);                    // missing set
    send_op(sset_pkg::OP_INSERT, 3, 0, 0, 5);
    send_op(sset_pkg::OP_MEMBER, 3, 0, 0, 5);
    send_op(sset_pkg::OP_CREATE, 3);
    send_op(sset_pkg::OP_READ, 3);                    // empty set
    send_op(sset_pkg::OP_INSERT, 3, 0, 0, 32'sh7fff_ffff);
    send_op(sset_pkg::OP_INSERT, 3, 0, 0, 32'sh8000_0000);
    send_op(sset_pkg::OP_INSERT, 3, 0, 0, 0);
    send_op(sset_pkg::OP_INSERT, 3, 0, 0, 0);         // duplicate
    send_op(sset_pkg::OP_MEMBER, 3, 0, 0, 0);
    send_op(sset_pkg::OP_MEMBER, 3, 0, 0, 1);
    send_op(sset_pkg::OP_REMOVE, 3, 0, 0, 1);         // absent value
    send_op(sset_pkg::OP_REMOVE, 3, 0, 0, 0);
    send_op(sset_pkg::OP_READ, 3);
    send_op(sset_pkg::OP_CREATE, 15);
    send_op(sset_pkg::OP_INSERT, 15, 0, 0, -1);
    send_op(sset_pkg::OP_UNION, 12, 3, 15);
    send_op(sset_pkg::OP_INTER, 12, 12, 3);           // destination is a source
    send_op(sset_pkg::OP_DIFF, 0, 3, 15);
    send_op(sset_pkg::OP_UNION, 1, 3, 9);             // missing source
    send_op(sset_pkg::OP_CREATE, 3);                  // clear existing set
    send_op(sset_pkg::OP_READ, 12);
    send_op(sset_pkg::OP_READ, 0);
    drain();
  endtask

  // Fill a set past capacity, then merge two full sets
  task automatic test_overflow();
    int k;
    send_op(sset_pkg::OP_CREATE, 4);
    send_op(sset_pkg::OP_CREATE, 5);
    for (k = 0; k < sset_pkg::CAPACITY + 4; k++)
      send_op(sset_pkg::OP_INSERT, 4, 0, 0, 2 * k);
    send_op(sset_pkg::OP_INSERT, 4, 0, 0, 1);         // full, drops largest
    for (k = 0; k < sset_pkg::CAPACITY; k++)
      send_op(sset_pkg::OP_INSERT, 5, 0, 0, 2 * k + 1001);
    send_op(sset_pkg::OP_UNION, 6, 4, 5);
    send_op(sset_pkg::OP_READ, 6);
    send_op(sset_pkg::OP_READ, 4);
    drain();
  endtask

  // Receiver holds off while reads pile up behind it
  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        int c;
        for (c = 0; c < 600; c++) @(negedge clk);
        recv_hold = 1'b0;
      end
      begin
        send_op(sset_pkg::OP_READ, 4);
        send_op(sset_pkg::OP_READ, 6);
        send_op(sset_pkg::OP_MEMBER, 4, 0, 0, 2);
      end
    join
    drain();
  endtask

  task automatic test_random(int count);
    int k;
    sset_pkg::op_t op;
    for (k = 0; k < count; k++) begin
      op = sset_pkg::op_t'($urandom_range(7));
      if ($urandom_range(9) == 0) op = sset_pkg::OP_CREATE;
      send_op(op, $urandom_range(7) + 8 * ($urandom_range(9) == 0),
              $urandom_range(7), $urandom_range(7), pick_value());
    end
    drain();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_overflow();
    test_backpressure();
    send_idle_pct = 37; recv_idle_pct = 54;
    test_random(20);
    send_idle_pct = 54; recv_idle_pct = 37;
    test_random(20);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(20);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

[sorted_set_store_engine_core.f]
hdl/sset_pkg.sv
hdl/sset_ram.sv
hdl/sorted_set_store_engine_core.sv
bench/sorted_set_store_engine_core_tb.sv
